// ===== sv/afk_pkg.sv =====
package afk_pkg;

   typedef struct packed {
      logic signed [15:0] angle_base;
      logic signed [15:0] angle_shoulder;
      logic signed [15:0] angle_wrist;
   } req_type;

   typedef struct packed {
      logic               pose_valid;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
   } rsp_type;

   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_HEIGHT = 3'd0,
      CSR_ARM_LENGTH  = 3'd1,
      CSR_JOINT2_MIN  = 3'd2,
      CSR_JOINT2_MAX  = 3'd3,
      CSR_JOINT3_MIN  = 3'd4,
      CSR_JOINT3_MAX  = 3'd5
   } csr_index_type;

   localparam logic signed [15:0] BASE_HEIGHT_RST = 16'sd4096;
   localparam logic signed [15:0] ARM_LENGTH_RST  = 16'sd2048;
   localparam logic signed [15:0] JOINT2_MIN_RST  = -16'sd16036;
   localparam logic signed [15:0] JOINT2_MAX_RST  = 16'sd3174;
   localparam logic signed [15:0] JOINT3_MIN_RST  = -16'sd9687;
   localparam logic signed [15:0] JOINT3_MAX_RST  = 16'sd9687;

   // turn fraction per Q4.12 radian, full and half angle
   localparam logic [31:0] PHASE_FULL = 32'd166886;
   localparam logic [31:0] PHASE_HALF = 32'd83443;

   // odd polynomial for sin(pi/2*u), Q30, lowest order first
   localparam logic [30:0] POLY_Q30 [5] = '{
      31'd1686629713, 31'd693598668, 31'd85569306, 31'd5026995, 31'd172272
   };
   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

   // length of the valid pipeline; its last register drives rsp_valid
   localparam int PIPE_LEN = 10;

endpackage

// ===== sv/afk_sincos.sv =====
module afk_sincos (
   input  logic               clock,
   input  logic [17:0]        phase,
   output logic signed [31:0] sin_out,
   output logic signed [31:0] cos_out
);
   import afk_pkg::*;

   // lane 0 evaluates at u, lane 1 at the complement
   logic [1:0]  quad_ff [5];
   logic [16:0] u_ff    [5][2];
   logic [30:0] x2_ff   [4][2];
   logic [30:0] acc_ff  [4][2];
   logic [16:0] u_in    [2];
   logic [30:0] x2_in   [2];
   logic [30:0] acc_in  [4][2];
   logic [30:0] q_in    [2];
   logic signed [31:0] sin_in, cos_in;
   logic [33:0] sq;
   logic [61:0] mul;
   logic [47:0] fin;
   logic [30:0] prev;

   always_comb begin
      u_in[0] = {1'b0, phase[15:0]};
      u_in[1] = 17'h10000 - {1'b0, phase[15:0]};
      for (int l = 0; l < 2; l++) begin
         sq       = 34'(u_in[l]) * 34'(u_in[l]);
         x2_in[l] = 31'(sq >> 2);
      end
   end

   // one horner step per stage
   always_comb begin
      for (int s = 0; s < 4; s++) begin
         for (int l = 0; l < 2; l++) begin
            prev = (s == 0) ? POLY_Q30[4] : acc_ff[(s == 0) ? 0 : s-1][l];
            mul  = 62'(prev) * 62'(x2_ff[s][l]);
            acc_in[s][l] = POLY_Q30[3-s] - 31'(mul >> 30);
         end
      end
   end

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         fin = 48'(acc_ff[3][l]) * 48'(u_ff[4][l]);
         q_in[l] = (fin[47:16] > 32'(ONE_Q30)) ? ONE_Q30 : fin[46:16];
      end
      case (quad_ff[4])
         2'd0: begin
            sin_in = 32'(q_in[0]);
            cos_in = 32'(q_in[1]);
         end
         2'd1: begin
            sin_in = 32'(q_in[1]);
            cos_in = -32'(q_in[0]);
         end
         2'd2: begin
            sin_in = -32'(q_in[0]);
            cos_in = -32'(q_in[1]);
         end
         default: begin
            sin_in = -32'(q_in[1]);
            cos_in = 32'(q_in[0]);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      quad_ff[0] <= phase[17:16];
      for (int s = 1; s < 5; s++) begin
         quad_ff[s] <= quad_ff[s-1];
      end
      for (int l = 0; l < 2; l++) begin
         u_ff[0][l]  <= u_in[l];
         x2_ff[0][l] <= x2_in[l];
         for (int s = 1; s < 5; s++) begin
            u_ff[s][l] <= u_ff[s-1][l];
         end
         for (int s = 1; s < 4; s++) begin
            x2_ff[s][l] <= x2_ff[s-1][l];
         end
         for (int s = 0; s < 4; s++) begin
            acc_ff[s][l] <= acc_in[s][l];
         end
      end
      sin_out <= sin_in;
      cos_out <= cos_in;
   end

endmodule

// ===== sv/arm_forward_kinematics.sv =====
// forward kinematics of a three-joint arm
// requests: start with req_data (three Q4.12 joint angles) is taken at any
// clock edge where busy is low; busy never rises, so a request may be given
// every cycle and the block sustains one pose per clock.
// results: rsp_valid pulses for one cycle with rsp_data for each request taken,
// in request order. pose_valid is clear and all other fields are zero when
// joint 2 or joint 3 is outside its limits.
// the receiver cannot stall: results are simply presented once.
// the path runs through the phase multiply, the sine/cosine pipeline (square,
// four polynomial steps, final scale), a product stage, a rounding stage and
// the arm length scale into the output register.
// csr: csr_valid/csr_ready write channel, csr_ready always high; csr_index
// selects base height, arm length and the joint 2 and 3 limits. write only
// while no request is in flight. unknown indexes are ignored.
// reset: synchronous, active high; clears the pipeline valid bits and
// loads the default link lengths and limits.
module arm_forward_kinematics (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  afk_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   output afk_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [afk_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [15:0]                      csr_data
);
   import afk_pkg::*;

   logic signed [15:0] d1_ff, a2_ff, j2lo_ff, j2hi_ff, j3lo_ff, j3hi_ff;
   logic               vld_ff [PIPE_LEN];
   logic               ok_ff  [PIPE_LEN];
   logic               ok_in, accept;
   logic [17:0]        ph_ff  [4];
   logic [17:0]        ph_in  [4];
   logic [31:0]        ext    [4];
   logic [31:0]        pm;
   logic signed [16:0] sum23;
   logic signed [31:0] s_w [4];
   logic signed [31:0] c_w [4];
   logic signed [63:0] p_ff [7];
   logic signed [31:0] xq_ff, yq_ff;
   logic signed [15:0] z_ff, z_in;
   logic signed [15:0] qt_ff [4];
   logic signed [15:0] qt_in [4];
   logic signed [63:0] zt, rz;
   rsp_type            rsp_ff, rsp_in;

   function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
      if (v > 64'sd32767) begin
         return 16'sh7fff;
      end else if (v < -64'sd32768) begin
         return 16'sh8000;
      end else begin
         return 16'(v);
      end
   endfunction

   function automatic logic signed [15:0] quat_round(input logic signed [63:0] v);
      logic signed [63:0] r;
      r = (v + 64'sd35184372088832) >>> 46;
      if (r > 64'sd16384) begin
         return 16'sd16384;
      end else if (r < -64'sd16384) begin
         return -16'sd16384;
      end else begin
         return 16'(r);
      end
   endfunction

   function automatic logic signed [63:0] round30(input logic signed [63:0] v);
      return (v + 64'sd536870912) >>> 30;
   endfunction

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_ff   <= BASE_HEIGHT_RST;
         a2_ff   <= ARM_LENGTH_RST;
         j2lo_ff <= JOINT2_MIN_RST;
         j2hi_ff <= JOINT2_MAX_RST;
         j3lo_ff <= JOINT3_MIN_RST;
         j3hi_ff <= JOINT3_MAX_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BASE_HEIGHT: d1_ff   <= csr_data;
            CSR_ARM_LENGTH:  a2_ff   <= csr_data;
            CSR_JOINT2_MIN:  j2lo_ff <= csr_data;
            CSR_JOINT2_MAX:  j2hi_ff <= csr_data;
            CSR_JOINT3_MIN:  j3lo_ff <= csr_data;
            CSR_JOINT3_MAX:  j3hi_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // phases: full t1, full t2, half t1, half (t2+t3); keep top 18 bits
   always_comb begin
      sum23  = 17'(req_data.angle_shoulder) + 17'(req_data.angle_wrist);
      ext[0] = 32'(req_data.angle_base);
      ext[1] = 32'(req_data.angle_shoulder);
      ext[2] = 32'(req_data.angle_base);
      ext[3] = 32'(sum23);
      for (int i = 0; i < 4; i++) begin
         pm       = ext[i] * ((i < 2) ? PHASE_FULL : PHASE_HALF);
         ph_in[i] = pm[31:14];
      end
      ok_in = (req_data.angle_shoulder >= j2lo_ff) && (req_data.angle_shoulder <= j2hi_ff)
           && (req_data.angle_wrist >= j3lo_ff) && (req_data.angle_wrist <= j3hi_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < PIPE_LEN; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= accept;
         for (int s = 1; s < PIPE_LEN; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      ok_ff[0] <= ok_in;
      for (int s = 1; s < PIPE_LEN; s++) begin
         ok_ff[s] <= ok_ff[s-1];
      end
      for (int i = 0; i < 4; i++) begin
         ph_ff[i] <= ph_in[i];
      end
   end

   for (genvar g = 0; g < 4; g++) begin : g_trig
      afk_sincos u_sincos (
         .clock   (clock),
         .phase   (ph_ff[g]),
         .sin_out (s_w[g]),
         .cos_out (c_w[g])
      );
   end

   // product stage
   always_ff @(posedge clock) begin
      p_ff[0] <= c_w[0] * c_w[1];
      p_ff[1] <= c_w[1] * s_w[0];
      p_ff[2] <= 64'(a2_ff) * 64'(s_w[1]);
      p_ff[3] <= c_w[2] * c_w[3];
      p_ff[4] <= s_w[2] * s_w[3];
      p_ff[5] <= c_w[2] * s_w[3];
      p_ff[6] <= s_w[2] * c_w[3];
   end

   // rounding stage
   always_comb begin
      rz       = round30(p_ff[2]);
      zt       = 64'(d1_ff) - rz;
      z_in     = sat16(zt);
      qt_in[0] = quat_round(p_ff[3]);
      qt_in[1] = quat_round(-p_ff[4]);
      qt_in[2] = quat_round(p_ff[5]);
      qt_in[3] = quat_round(p_ff[6]);
   end

   always_ff @(posedge clock) begin
      xq_ff <= 32'(round30(p_ff[0]));
      yq_ff <= 32'(round30(p_ff[1]));
      z_ff  <= z_in;
      for (int i = 0; i < 4; i++) begin
         qt_ff[i] <= qt_in[i];
      end
   end

   // scale by arm length, zero the pose when a limit is violated
   always_comb begin
      rsp_in = '0;
      if (ok_ff[8]) begin
         rsp_in.pose_valid = 1'b1;
         rsp_in.pos_x      = sat16(round30(64'(a2_ff) * 64'(xq_ff)));
         rsp_in.pos_y      = sat16(round30(64'(a2_ff) * 64'(yq_ff)));
         rsp_in.pos_z      = z_ff;
         rsp_in.quat_w     = qt_ff[0];
         rsp_in.quat_x     = qt_ff[1];
         rsp_in.quat_y     = qt_ff[2];
         rsp_in.quat_z     = qt_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = vld_ff[PIPE_LEN-1];
   assign rsp_data  = rsp_ff;

endmodule
